// File: rtl/c8ie_pkg.sv
// Shared package for the CHIP-8 instruction executor.
// Holds item codes, status codes, the ALU result type and the font and BCD helpers.
// No dependencies.
package c8ie_pkg;

    localparam int MEM_BYTES     = 4096;
    localparam int MEM_AW        = 12;
    localparam int STACK_DEPTH   = 16;
    localparam int SCREEN_PIXELS = 2048;
    localparam int PIX_AW        = 11;

    localparam logic [1:0] ACT_EXEC  = 2'd0;
    localparam logic [1:0] ACT_WRMEM = 2'd1;
    localparam logic [1:0] ACT_KEY   = 2'd2;
    localparam logic [1:0] ACT_PIXEL = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNKNOWN   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_UNDERFLOW = 2'd3;

    localparam logic [11:0] PC_RESET = 12'h200;

    typedef struct packed {
        logic       ok;
        logic       wflag;
        logic [7:0] res;
        logic       flag;
    } alu_res_t;

    function automatic logic [7:0] font_byte(input logic [11:0] a);
        logic [7:0] b;
        b = 8'h00;
        if (a < 12'd80) begin
            case (a[6:0])
                7'd0, 7'd4, 7'd10, 7'd12, 7'd14, 7'd15, 7'd17, 7'd19, 7'd22,
                7'd25, 7'd27, 7'd29, 7'd30, 7'd32, 7'd34, 7'd35, 7'd40, 7'd42,
                7'd44, 7'd45, 7'd47, 7'd49, 7'd50, 7'd52, 7'd60, 7'd64, 7'd70,
                7'd72, 7'd74, 7'd75, 7'd77:
                    b = 8'hF0;
                7'd1, 7'd2, 7'd3, 7'd20, 7'd21, 7'd33, 7'd41, 7'd43, 7'd46,
                7'd51, 7'd53, 7'd54, 7'd56, 7'd58, 7'd66, 7'd67, 7'd68:
                    b = 8'h90;
                7'd5, 7'd7, 7'd8, 7'd37:
                    b = 8'h20;
                7'd6:
                    b = 8'h60;
                7'd9:
                    b = 8'h70;
                7'd11, 7'd16, 7'd18, 7'd23, 7'd24, 7'd28, 7'd36, 7'd48:
                    b = 8'h10;
                7'd13, 7'd26, 7'd31, 7'd61, 7'd62, 7'd63, 7'd71, 7'd73, 7'd76,
                7'd78, 7'd79:
                    b = 8'h80;
                7'd38, 7'd39:
                    b = 8'h40;
                7'd55, 7'd57, 7'd59, 7'd65, 7'd69:
                    b = 8'hE0;
                default:
                    b = 8'h00;
            endcase
        end
        return b;
    endfunction

    function automatic logic [1:0] bcd_hund(input logic [7:0] v);
        return (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    endfunction

    function automatic logic [6:0] bcd_rem(input logic [7:0] v);
        logic [7:0] r;
        r = v - ({6'd0, bcd_hund(v)} * 8'd100);
        return r[6:0];
    endfunction

    // Tens by multiply with 205/2048, exact below one hundred.
    function automatic logic [3:0] bcd_tens(input logic [7:0] v);
        logic [14:0] p;
        p = {8'd0, bcd_rem(v)} * 15'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] bcd_ones(input logic [7:0] v);
        logic [6:0] r;
        r = bcd_rem(v) - ({3'd0, bcd_tens(v)} * 7'd10);
        return r[3:0];
    endfunction

endpackage

// File: rtl/c8ie_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module c8ie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/c8ie_alu.sv
// Register-to-register ALU for the 8XYn instruction group.
// Depends on c8ie_pkg.
module c8ie_alu (
    input  logic [3:0]          fn,
    input  logic [7:0]          vx,
    input  logic [7:0]          vy,
    output c8ie_pkg::alu_res_t  res
);
    import c8ie_pkg::*;

    logic [8:0] sum;

    assign sum = {1'b0, vx} + {1'b0, vy};

    always_comb
    begin
        res = '{ok: 1'b1, wflag: 1'b1, res: 8'h00, flag: 1'b0};
        case (fn)
            4'h0: begin res.res = vy;      res.wflag = 1'b0; end
            4'h1: begin res.res = vx | vy; res.wflag = 1'b0; end
            4'h2: begin res.res = vx & vy; res.wflag = 1'b0; end
            4'h3: begin res.res = vx ^ vy; res.wflag = 1'b0; end
            4'h4: begin res.res = sum[7:0]; res.flag = sum[8]; end
            4'h5: begin res.res = vx - vy;  res.flag = (vx >= vy); end
            4'h6: begin res.res = {1'b0, vx[7:1]}; res.flag = vx[0]; end
            4'h7: begin res.res = vy - vx;  res.flag = (vy >= vx); end
            4'hE: begin res.res = {vx[6:0], 1'b0}; res.flag = vx[7]; end
            default:
            begin
                res.ok    = 1'b0;
                res.wflag = 1'b0;
            end
        endcase
    end

endmodule

// File: rtl/chip8_instruction_executor_unit.sv
// CHIP-8 instruction executor, top level.
// Depends on c8ie_pkg, c8ie_ram and c8ie_alu.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one item: an action code with its
//   operand fields. Action 0 fetches and executes the instruction at the program
//   counter, action 1 writes one memory byte, action 2 sets one key, action 3 reads
//   one display pixel. Every item yields exactly one result item on the output
//   channel (out_valid / out_stall).
//   FX55/FX65 move V0..VX one register at a time between memory at I and the
//   registers; draw DXYN is bounded by the one-pixel-per-cycle frame buffer port;
//   00E0 sweeps the frame buffer one pixel a cycle.
//   One item is in work at a time; in_stall is high while it runs.
//   Reset: a clearing pass over all of memory loads the font at 0..79, zeros the rest
//   of memory, the frame buffer and the data registers; in_stall stays high during it.
//   A stalled output holds its result; the next item is still accepted and runs up
//   to its result, which waits until the output register frees.
//   Timers decrement once per executed instruction.
module chip8_instruction_executor_unit #(
    parameter int STACK_DEPTH = c8ie_pkg::STACK_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [11:0] mem_address,
    input  logic [7:0]  mem_data,
    input  logic [3:0]  key_number,
    input  logic        key_pressed,
    input  logic [10:0] pixel_index,
    input  logic [7:0]  random_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] program_counter,
    output logic [15:0] opcode,
    output logic        redraw,
    output logic        sound_on,
    output logic [1:0]  status,
    output logic        pixel_value
);
    import c8ie_pkg::*;

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int SI_W = $clog2(STACK_DEPTH);

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_PIX, S_F1, S_F2, S_F3, S_F4, S_EXEC, S_RET, S_WRF,
        S_BCD, S_SVRD, S_SVWR, S_LDRD, S_LDWR, S_DRM, S_DRR, S_DRP, S_DRW,
        S_FBCLR, S_DONE
    } state_t;

    state_t      state_reg;
    logic [11:0] clr_cnt_reg;
    logic [1:0]  act_reg;
    logic [7:0]  rnd_reg;
    logic [7:0]  op_hi_reg;
    logic [15:0] op_reg;
    logic [7:0]  vx_reg;
    logic [7:0]  vy_reg;
    logic [15:0] i_reg;
    logic [11:0] pc_reg;
    logic [SP_W-1:0] sp_reg;
    logic [7:0]  dly_reg;
    logic [7:0]  snd_reg;
    logic [15:0] key_reg;
    logic [3:0]  k_reg;
    logic [2:0]  col_reg;
    logic [7:0]  bits_reg;
    logic        flag_reg;
    logic        redraw_reg;
    logic [1:0]  status_reg;
    logic        pix_reg;

    logic        out_valid_reg;
    logic [11:0] pc_out_reg;
    logic [15:0] op_out_reg;
    logic        redraw_out_reg;
    logic        sound_out_reg;
    logic [1:0]  status_out_reg;
    logic        pix_out_reg;

    // memory ports
    logic        mem_we;
    logic [11:0] mem_wa, mem_ra;
    logic [7:0]  mem_wd, mem_rd;
    logic        fb_we;
    logic [10:0] fb_wa, fb_ra;
    logic        fb_wd, fb_rd;
    logic        v_we;
    logic [3:0]  v_wa, v_ra;
    logic [7:0]  v_wd, v_rd;
    logic        stk_we;
    logic [SI_W-1:0] stk_wa, stk_ra;
    logic [11:0] stk_wd, stk_rd;

    logic        in_acc;
    logic        out_free;
    alu_res_t    alu;
    logic [3:0]  op_x;
    logic [7:0]  op_nn;
    logic [11:0] pc_next, pc_skip;
    logic [11:0] i_k;
    logic [10:0] draw_addr;
    logic [4:0]  draw_py;
    logic [5:0]  draw_px;
    logic        stk_full;
    logic        last_col, last_row;
    logic [7:0]  dly_dec, snd_dec;

    c8ie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .clk(clk), .we(mem_we), .waddr(mem_wa), .wdata(mem_wd), .raddr(mem_ra), .rdata(mem_rd)
    );
    c8ie_ram #(.WIDTH(1), .DEPTH(SCREEN_PIXELS)) u_fb (
        .clk(clk), .we(fb_we), .waddr(fb_wa), .wdata(fb_wd), .raddr(fb_ra), .rdata(fb_rd)
    );
    c8ie_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
        .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd)
    );
    c8ie_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stk (
        .clk(clk), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd)
    );
    c8ie_alu u_alu (.fn(op_reg[3:0]), .vx(vx_reg), .vy(vy_reg), .res(alu));

    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign op_x      = op_reg[11:8];
    assign op_nn     = op_reg[7:0];
    assign pc_next   = pc_reg + 12'd2;
    assign pc_skip   = pc_reg + 12'd4;
    assign i_k       = i_reg[11:0] + {8'd0, k_reg};
    assign draw_py   = vy_reg[4:0] + {1'b0, k_reg};
    assign draw_px   = vx_reg[5:0] + {3'd0, col_reg};
    assign draw_addr = {draw_py, draw_px};
    assign stk_full  = (sp_reg == SP_W'(STACK_DEPTH));
    assign last_col  = (col_reg == 3'd7);
    assign last_row  = (k_reg == (op_reg[3:0] - 4'd1));
    assign dly_dec   = (dly_reg != 8'd0) ? dly_reg - 8'd1 : dly_reg;
    assign snd_dec   = (snd_reg != 8'd0) ? snd_reg - 8'd1 : snd_reg;
    assign stk_ra    = SI_W'(sp_reg - SP_W'(1));
    assign stk_wa    = SI_W'(sp_reg);
    assign stk_wd    = pc_reg;

    // Memory port steering per state.
    always_comb
    begin
        mem_we = 1'b0; mem_wa = i_k; mem_wd = 8'h00; mem_ra = i_k;
        fb_we  = 1'b0; fb_wa = draw_addr; fb_wd = 1'b0; fb_ra = draw_addr;
        v_we   = 1'b0; v_wa = op_x; v_wd = 8'h00; v_ra = k_reg;
        stk_we = 1'b0;
        case (state_reg)
            S_CLR:
            begin
                mem_we = 1'b1; mem_wa = clr_cnt_reg; mem_wd = font_byte(clr_cnt_reg);
                fb_we  = 1'b1; fb_wa = clr_cnt_reg[10:0];
                v_we   = 1'b1; v_wa = clr_cnt_reg[3:0];
            end
            S_IDLE:
            begin
                mem_ra = pc_reg;
                fb_ra  = pixel_index;
                if (in_acc && action == ACT_WRMEM)
                begin
                    mem_we = 1'b1; mem_wa = mem_address; mem_wd = mem_data;
                end
            end
            S_F1:  mem_ra = pc_reg + 12'd1;
            S_F2:  v_ra = op_hi_reg[3:0];
            S_F3:  v_ra = (op_reg[15:12] == 4'hB) ? 4'h0 : op_reg[7:4];
            S_EXEC:
            begin
                case (op_reg[15:12])
                    4'h2: stk_we = !stk_full;
                    4'h6: begin v_we = 1'b1; v_wd = op_nn; end
                    4'h7: begin v_we = 1'b1; v_wd = vx_reg + op_nn; end
                    4'h8: begin v_we = alu.ok; v_wd = alu.res; end
                    4'hC: begin v_we = 1'b1; v_wd = op_nn & rnd_reg; end
                    4'hF: begin v_we = (op_nn == 8'h07); v_wd = dly_reg; end
                    default: v_we = 1'b0;
                endcase
            end
            S_WRF: begin v_we = 1'b1; v_wa = 4'hF; v_wd = {7'd0, flag_reg}; end
            S_BCD:
            begin
                mem_we = 1'b1;
                case (k_reg[1:0])
                    2'd0:    mem_wd = {6'd0, bcd_hund(vx_reg)};
                    2'd1:    mem_wd = {4'd0, bcd_tens(vx_reg)};
                    default: mem_wd = {4'd0, bcd_ones(vx_reg)};
                endcase
            end
            S_SVWR: begin mem_we = 1'b1; mem_wd = v_rd; end
            S_LDWR: begin v_we = 1'b1; v_wa = k_reg; v_wd = mem_rd; end
            S_DRW:  begin fb_we = 1'b1; fb_wd = !fb_rd; end
            S_FBCLR: begin fb_we = 1'b1; fb_wa = clr_cnt_reg[10:0]; end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            clr_cnt_reg    <= '0;
            i_reg          <= '0;
            pc_reg         <= PC_RESET;
            sp_reg         <= '0;
            dly_reg        <= '0;
            snd_reg        <= '0;
            key_reg        <= '0;
            out_valid_reg  <= 1'b0;
            act_reg        <= ACT_EXEC;
            k_reg          <= '0;
            col_reg        <= '0;
            flag_reg       <= 1'b0;
            redraw_reg     <= 1'b0;
            status_reg     <= ST_OK;
            pix_reg        <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 12'd1;
                    if (clr_cnt_reg == 12'hFFF)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        act_reg    <= action;
                        rnd_reg    <= random_byte;
                        redraw_reg <= 1'b0;
                        status_reg <= ST_OK;
                        pix_reg    <= 1'b0;
                        case (action)
                            ACT_EXEC:  state_reg <= S_F1;
                            ACT_PIXEL: state_reg <= S_PIX;
                            ACT_KEY:
                            begin
                                key_reg[key_number] <= key_pressed;
                                state_reg <= S_DONE;
                            end
                            default:   state_reg <= S_DONE;
                        endcase
                    end
                end
                S_PIX:
                begin
                    pix_reg   <= fb_rd;
                    state_reg <= S_DONE;
                end
                S_F1:
                begin
                    op_hi_reg <= mem_rd;
                    state_reg <= S_F2;
                end
                S_F2:
                begin
                    op_reg    <= {op_hi_reg, mem_rd};
                    state_reg <= S_F3;
                end
                S_F3:
                begin
                    vx_reg    <= v_rd;
                    state_reg <= S_F4;
                end
                S_F4:
                begin
                    vy_reg    <= v_rd;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg <= S_DONE;
                    pc_reg    <= pc_next;
                    k_reg     <= '0;
                    col_reg   <= '0;
                    case (op_reg[15:12])
                        4'h0:
                        begin
                            if (op_reg == 16'h00E0)
                            begin
                                redraw_reg  <= 1'b1;
                                clr_cnt_reg <= '0;
                                state_reg   <= S_FBCLR;
                            end
                            else if (op_reg == 16'h00EE)
                            begin
                                pc_reg <= pc_reg;
                                if (sp_reg == '0)
                                begin
                                    status_reg <= ST_UNDERFLOW;
                                end
                                else
                                begin
                                    state_reg <= S_RET;
                                end
                            end
                            else
                            begin
                                pc_reg     <= pc_reg;
                                status_reg <= ST_UNKNOWN;
                            end
                        end
                        4'h1: pc_reg <= op_reg[11:0];
                        4'h2:
                        begin
                            if (stk_full)
                            begin
                                pc_reg     <= pc_reg;
                                status_reg <= ST_OVERFLOW;
                            end
                            else
                            begin
                                sp_reg <= sp_reg + SP_W'(1);
                                pc_reg <= op_reg[11:0];
                            end
                        end
                        4'h3: pc_reg <= (vx_reg == op_nn) ? pc_skip : pc_next;
                        4'h4: pc_reg <= (vx_reg != op_nn) ? pc_skip : pc_next;
                        4'h5: pc_reg <= (vx_reg == vy_reg) ? pc_skip : pc_next;
                        4'h9: pc_reg <= (vx_reg != vy_reg) ? pc_skip : pc_next;
                        4'h8:
                        begin
                            if (!alu.ok)
                            begin
                                pc_reg     <= pc_reg;
                                status_reg <= ST_UNKNOWN;
                            end
                            else if (alu.wflag)
                            begin
                                flag_reg  <= alu.flag;
                                state_reg <= S_WRF;
                            end
                        end
                        4'hA: i_reg <= {4'd0, op_reg[11:0]};
                        4'hB: pc_reg <= op_reg[11:0] + {4'd0, vy_reg};
                        4'hD:
                        begin
                            redraw_reg <= 1'b1;
                            flag_reg   <= 1'b0;
                            state_reg  <= (op_reg[3:0] == 4'd0) ? S_WRF : S_DRM;
                        end
                        4'hE:
                        begin
                            if (op_nn == 8'h9E)
                            begin
                                pc_reg <= key_reg[vx_reg[3:0]] ? pc_skip : pc_next;
                            end
                            else if (op_nn == 8'hA1)
                            begin
                                pc_reg <= key_reg[vx_reg[3:0]] ? pc_next : pc_skip;
                            end
                            else
                            begin
                                pc_reg     <= pc_reg;
                                status_reg <= ST_UNKNOWN;
                            end
                        end
                        4'hF:
                        begin
                            case (op_nn)
                                8'h07: pc_reg <= pc_next;
                                8'h15: dly_reg <= vx_reg;
                                8'h18: snd_reg <= vx_reg;
                                8'h1E: i_reg <= i_reg + {8'd0, vx_reg};
                                8'h29: i_reg <= {10'd0, vx_reg[3:0], 2'b00}
                                              + {12'd0, vx_reg[3:0]};
                                8'h33: state_reg <= S_BCD;
                                8'h55: state_reg <= S_SVRD;
                                8'h65: state_reg <= S_LDRD;
                                default:
                                begin
                                    pc_reg     <= pc_reg;
                                    status_reg <= ST_UNKNOWN;
                                end
                            endcase
                        end
                        default: pc_reg <= pc_next;
                    endcase
                end
                S_RET:
                begin
                    pc_reg    <= stk_rd + 12'd2;
                    sp_reg    <= sp_reg - SP_W'(1);
                    state_reg <= S_DONE;
                end
                S_WRF: state_reg <= S_DONE;
                S_BCD:
                begin
                    k_reg <= k_reg + 4'd1;
                    if (k_reg == 4'd2)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_SVRD: state_reg <= S_SVWR;
                S_LDRD: state_reg <= S_LDWR;
                S_SVWR, S_LDWR:
                begin
                    // advance to the next register, or bump the index past the block
                    k_reg     <= k_reg + 4'd1;
                    state_reg <= (state_reg == S_SVWR) ? S_SVRD : S_LDRD;
                    if (k_reg == op_x)
                    begin
                        i_reg     <= i_reg + {12'd0, op_x} + 16'd1;
                        state_reg <= S_DONE;
                    end
                end
                S_DRM: state_reg <= S_DRR;
                S_DRR:
                begin
                    bits_reg  <= mem_rd;
                    col_reg   <= '0;
                    state_reg <= S_DRP;
                end
                S_DRP, S_DRW:
                begin
                    if (state_reg == S_DRW && fb_rd)
                    begin
                        flag_reg <= 1'b1;
                    end
                    if (state_reg == S_DRP && bits_reg[3'd7 - col_reg])
                    begin
                        state_reg <= S_DRW;
                    end
                    else if (!last_col)
                    begin
                        col_reg   <= col_reg + 3'd1;
                        state_reg <= S_DRP;
                    end
                    else if (last_row)
                    begin
                        state_reg <= S_WRF;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 4'd1;
                        state_reg <= S_DRM;
                    end
                end
                S_FBCLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 12'd1;
                    if (clr_cnt_reg[10:0] == '1)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    // hold the result until the output register frees
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        pc_out_reg     <= pc_reg;
                        op_out_reg     <= (act_reg == ACT_EXEC) ? op_reg : 16'h0000;
                        redraw_out_reg <= redraw_reg;
                        status_out_reg <= status_reg;
                        pix_out_reg    <= pix_reg;
                        if (act_reg == ACT_EXEC)
                        begin
                            dly_reg       <= dly_dec;
                            snd_reg       <= snd_dec;
                            sound_out_reg <= (snd_dec != 8'd0);
                        end
                        else
                        begin
                            sound_out_reg <= (snd_reg != 8'd0);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign program_counter = pc_out_reg;
    assign opcode          = op_out_reg;
    assign redraw          = redraw_out_reg;
    assign sound_on        = sound_out_reg;
    assign status          = status_out_reg;
    assign pixel_value     = pix_out_reg;

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the done state");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack depth beyond its limit");

    a_pixel_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && pix_out_reg |-> op_out_reg == 16'h0000 && !redraw_out_reg)
        else $error("pixel value on an instruction result");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg != S_CLR && state_reg != S_IDLE)
        else $error("accepted item did not start work");

endmodule
